// ===== rtl/bmhpq_pkg.sv =====
// Shared types and codes of the binary max-heap priority queue.
// No dependencies.
package bmhpq_pkg;

    localparam int DEF_HEAP_DEPTH = 64;

    localparam int ACT_W   = 2;
    localparam int PRIO_W  = 8;
    localparam int JOB_W   = 16;
    localparam int PAGES_W = 16;
    localparam int STAT_W  = 2;
    localparam int CNT_OUT_W = 7;

    // action codes; code three behaves as a peek
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [JOB_W-1:0]   job;
        logic [PAGES_W-1:0] pages;
    } t_job;

    localparam int JOB_ENTRY_W = $bits(t_job);

endpackage

// ===== rtl/bmhpq_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module bmhpq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/binary_max_heap_priority_queue.sv =====
// Binary max-heap priority queue of jobs, top level and sequencer.
// Depends on bmhpq_pkg and bmhpq_ram.
//
//  channel  direction  handshake                 beat fields
//  -------  ---------  ------------------------  ------------------------------------
//  in       in         i_in_valid / o_in_stall   action, new_priority, new_job_number,
//                                                new_pages
//  out      out        o_out_valid / i_out_stall status, top_valid, top_priority,
//                                                top_job_number, top_pages, item_count
//
// Beat flow: peek, insert into a full heap and remove from an empty heap or of the last entry
// go straight to the result; insert sifts up from the new leaf, remove first fetches the last
// entry and sifts it down from the root. Each sift makes up to log2 HEAP_DEPTH parent/child
// compares; each level issues a read of the heap RAM, then compares and writes back.
// Synchronous active-low reset clears the count, the sequencer and the output valid;
// the heap RAM is not cleared, entries past the count are never read as data.
// One beat is in work at a time; a new beat is taken while a result waits on a stall.
module binary_max_heap_priority_queue #(
    parameter int HEAP_DEPTH = bmhpq_pkg::DEF_HEAP_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bmhpq_pkg::ACT_W-1:0]       i_action,
    input  logic [bmhpq_pkg::PRIO_W-1:0]      i_new_priority,
    input  logic [bmhpq_pkg::JOB_W-1:0]       i_new_job_number,
    input  logic [bmhpq_pkg::PAGES_W-1:0]     i_new_pages,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bmhpq_pkg::STAT_W-1:0]      o_status,
    output logic                              o_top_valid,
    output logic [bmhpq_pkg::PRIO_W-1:0]      o_top_priority,
    output logic [bmhpq_pkg::JOB_W-1:0]       o_top_job_number,
    output logic [bmhpq_pkg::PAGES_W-1:0]     o_top_pages,
    output logic [bmhpq_pkg::CNT_OUT_W-1:0]   o_item_count
);

    import bmhpq_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);       // heap address width
    localparam int CW = $clog2(HEAP_DEPTH + 1);   // count holds 0..HEAP_DEPTH
    localparam int LW = AW + 2;                   // child index, may pass the depth

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_RD   = 3'd1;   // issue parent read or finish at root
    localparam logic [2:0] S_UP_CMP  = 3'd2;   // parent data back: move it down or land
    localparam logic [2:0] S_LAST_RD = 3'd3;   // last entry back, it becomes the mover
    localparam logic [2:0] S_DN_RD   = 3'd4;   // issue both child reads or land
    localparam logic [2:0] S_DN_CMP  = 3'd5;   // children back: promote one or land
    localparam logic [2:0] S_DONE    = 3'd6;   // hand the result to the output register

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos,   n_pos;     // current hole position
    logic [AW-1:0] r_near,  n_near;    // parent (sift up) or left child (sift down)
    t_job          r_item,  n_item;    // entry being moved
    logic [STAT_W-1:0] r_stat, n_stat;
    t_job          r_top;              // copy of the root entry

    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic              r_out_top_valid;
    t_job              r_out_top;
    logic [CW-1:0]     r_out_count;
    logic              out_load;

    // RAM ports
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_job          w_wdata;
    logic [AW-1:0] w_raddr_a;
    logic [AW-1:0] w_raddr_b;
    logic [JOB_ENTRY_W-1:0] w_rdata_a;
    logic [JOB_ENTRY_W-1:0] w_rdata_b;
    t_job          rd_a;
    t_job          rd_b;

    // address arithmetic
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] pos_m1;
    logic [AW-1:0] parent;
    logic [LW-1:0] left_w;
    logic [LW-1:0] right_w;
    logic [LW-1:0] near_left_w;
    logic [LW-1:0] near_right_w;
    logic [LW-1:0] count_w;
    logic          pick_right;
    t_job          pick_item;
    logic          in_accept;
    logic [31:0]   count_wide;

    assign rd_a = t_job'(w_rdata_a);
    assign rd_b = t_job'(w_rdata_b);

    assign cnt_m1       = r_count - CW'(1);
    assign pos_m1       = r_pos - AW'(1);
    assign parent       = pos_m1 >> 1;
    assign left_w       = LW'({r_pos, 1'b1});
    assign right_w      = left_w + LW'(1);
    assign near_left_w  = LW'(r_near);
    assign near_right_w = near_left_w + LW'(1);
    assign count_w      = LW'(r_count);

    // left wins a tie; right only counts when it lies inside the heap
    assign pick_right = (near_right_w < count_w) && (rd_b.prio > rd_a.prio);
    assign pick_item  = pick_right ? rd_b : rd_a;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_near      = r_near;
        n_item      = r_item;
        n_stat      = r_stat;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = r_item;
        w_raddr_a   = parent;
        w_raddr_b   = right_w[AW-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_stat  = STAT_DONE;
                    n_state = S_DONE;
                    case (i_action)
                        ACT_INSERT: begin
                            if (r_count >= CW'(HEAP_DEPTH)) begin
                                n_stat = STAT_FULL;
                            end else begin
                                n_item.prio  = i_new_priority;
                                n_item.job   = i_new_job_number;
                                n_item.pages = i_new_pages;
                                n_pos   = r_count[AW-1:0];
                                n_count = r_count + CW'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        ACT_REMOVE: begin
                            if (r_count == '0) begin
                                n_stat = STAT_EMPTY;
                            end else begin
                                n_count   = cnt_m1;
                                w_raddr_a = cnt_m1[AW-1:0];
                                if (cnt_m1 != '0) begin
                                    n_state = S_LAST_RD;
                                end
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_stat = STAT_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_raddr_a = parent;
                    n_near    = parent;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (rd_a.prio < r_item.prio) begin
                    w_wdata = rd_a;
                    n_pos   = r_near;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LAST_RD: begin
                n_item  = rd_a;
                n_pos   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (left_w >= count_w) begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_raddr_a = left_w[AW-1:0];
                    w_raddr_b = right_w[AW-1:0];
                    n_near    = left_w[AW-1:0];
                    n_state   = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (pick_item.prio <= r_item.prio) begin
                    n_state = S_DONE;
                end else begin
                    w_wdata = pick_item;
                    n_pos   = pick_right ? near_right_w[AW-1:0] : r_near;
                    n_state = S_DN_RD;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_near <= n_near;
        r_item <= n_item;
        r_stat <= n_stat;
        if (w_we && (w_waddr == '0)) begin
            r_top <= w_wdata;
        end
        if (out_load) begin
            r_out_status    <= r_stat;
            r_out_top_valid <= (r_count != '0);
            r_out_top       <= (r_count != '0) ? r_top : '0;
            r_out_count     <= r_count;
        end
    end

    bmhpq_ram #(
        .WIDTH (JOB_ENTRY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    // item count reports the low seven bits of the count
    assign count_wide = 32'(r_out_count);

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_top_valid      = r_out_top_valid;
    assign o_top_priority   = r_out_top.prio;
    assign o_top_job_number = r_out_top.job;
    assign o_top_pages      = r_out_top.pages;
    assign o_item_count     = count_wide[CNT_OUT_W-1:0];

endmodule

// ===== tb/bmhpq_checker.sv =====
`timescale 1ns / 100ps
// Checker for the binary max-heap priority queue: keeps a shadow heap of jobs and the
// top-entry report each request beat should produce, compares every output beat.
// Depends on bmhpq_pkg.
module bmhpq_checker #(
    parameter int HEAP_DEPTH = bmhpq_pkg::DEF_HEAP_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [bmhpq_pkg::ACT_W-1:0]       i_action,
    input  logic [bmhpq_pkg::PRIO_W-1:0]      i_new_priority,
    input  logic [bmhpq_pkg::JOB_W-1:0]       i_new_job_number,
    input  logic [bmhpq_pkg::PAGES_W-1:0]     i_new_pages,

    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [bmhpq_pkg::STAT_W-1:0]      i_status,
    input  logic                              i_top_valid,
    input  logic [bmhpq_pkg::PRIO_W-1:0]      i_top_priority,
    input  logic [bmhpq_pkg::JOB_W-1:0]       i_top_job_number,
    input  logic [bmhpq_pkg::PAGES_W-1:0]     i_top_pages,
    input  logic [bmhpq_pkg::CNT_OUT_W-1:0]   i_item_count,

    output int                                o_fail_count,
    output int                                o_pending
);

    import bmhpq_pkg::*;

    typedef struct {
        logic [STAT_W-1:0]    status;
        logic                 top_valid;
        t_job                 top;
        logic [CNT_OUT_W-1:0] count;
    } t_top_report;

    // counters start at zero as ints do
    t_job        job_heap [HEAP_DEPTH];
    int          jobs_held;
    t_top_report tops_due [$];
    int          faults;
    int          reports_seen;

    assign o_fail_count = faults;

    function automatic void swap_jobs(input int a, input int b);
        t_job tmp;
        tmp         = job_heap[a];
        job_heap[a] = job_heap[b];
        job_heap[b] = tmp;
    endfunction

    // Apply one request to the shadow heap, return the report it should give.
    function automatic t_top_report serve_request(input logic [ACT_W-1:0] act,
                                                  input t_job fresh);
        t_top_report rpt;
        int          pos;
        int          up;
        int          pick;
        bit          moving;
        rpt.status = STAT_DONE;
        case (act)
            ACT_INSERT: begin
                if (jobs_held >= HEAP_DEPTH) begin
                    rpt.status = STAT_FULL;
                end else begin
                    pos = jobs_held;
                    job_heap[pos] = fresh;
                    jobs_held++;
                    moving = 1'b1;
                    // climb while the parent is strictly lower
                    while (moving && pos > 0) begin
                        up = (pos - 1) / 2;
                        if (job_heap[up].prio < job_heap[pos].prio) begin
                            swap_jobs(up, pos);
                            pos = up;
                        end else begin
                            moving = 1'b0;
                        end
                    end
                end
            end
            ACT_REMOVE: begin
                if (jobs_held == 0) begin
                    rpt.status = STAT_EMPTY;
                end else begin
                    jobs_held--;
                    job_heap[0] = job_heap[jobs_held];
                    pos = 0;
                    moving = 1'b1;
                    // left child wins a tie; stop unless the child is strictly higher
                    while (moving && 2 * pos + 1 < jobs_held) begin
                        pick = 2 * pos + 1;
                        if (pick + 1 < jobs_held && job_heap[pick + 1].prio > job_heap[pick].prio) begin
                            pick = pick + 1;
                        end
                        if (job_heap[pick].prio > job_heap[pos].prio) begin
                            swap_jobs(pos, pick);
                            pos = pick;
                        end else begin
                            moving = 1'b0;
                        end
                    end
                end
            end
            default: begin
                // peek, and code three which acts as one
                if (jobs_held == 0) begin
                    rpt.status = STAT_EMPTY;
                end
            end
        endcase
        rpt.top_valid = (jobs_held > 0);
        rpt.top       = rpt.top_valid ? job_heap[0] : '0;
        rpt.count     = CNT_OUT_W'(jobs_held);
        return rpt;
    endfunction

    task automatic report_fault(input string msg);
        faults++;
        if (faults <= 10) begin
            $display("[%0t] mismatch on report %0d: %s", $time, reports_seen, msg);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            report_fault($sformatf("%s expected %0h, got %0h", what, want, got));
        end
    endtask

    always @(posedge i_clk) begin
        t_top_report want;
        t_job        incoming;
        if (!i_rst_n) begin
            jobs_held = 0;
            tops_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                incoming = {i_new_priority, i_new_job_number, i_new_pages};
                tops_due.push_back(serve_request(i_action, incoming));
            end
            if (i_out_valid && !i_out_stall) begin
                reports_seen++;
                if (tops_due.size() == 0) begin
                    report_fault($sformatf("report beat with none due: status %0h count %0d",
                                           i_status, i_item_count));
                end else begin
                    want = tops_due.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("top_valid", 32'(want.top_valid), 32'(i_top_valid));
                    check_field("top_priority", 32'(want.top.prio), 32'(i_top_priority));
                    check_field("top_job_number", 32'(want.top.job),
                                32'(i_top_job_number));
                    check_field("top_pages", 32'(want.top.pages), 32'(i_top_pages));
                    check_field("item_count", 32'(want.count), 32'(i_item_count));
                end
            end
        end
        o_pending <= tops_due.size();
    end

endmodule

// ===== tb/tb_binary_max_heap_priority_queue.sv =====
`timescale 1ns / 100ps
// Top of the heap priority queue testbench: clock, reset, request beats and verdict.
// Depends on bmhpq_pkg, binary_max_heap_priority_queue and bmhpq_checker.
module tb_binary_max_heap_priority_queue;

    import bmhpq_pkg::*;

    localparam int HEAP_DEPTH     = 64;
    localparam int TOTAL_BEATS    = 1600;
    localparam int CALM_BEATS     = 200;   // tail with no gaps and no stalls
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any beat moving
    localparam int TAIL_CYCLES    = 40;    // longer than the slowest beat

    // the unused action code; the block treats it as a peek
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    typedef enum int {
        LEAN_FILL,   // mostly inserts, runs into a full heap
        LEAN_DRAIN,  // mostly removes, runs into an empty heap
        LEAN_EVEN,   // balanced mix
        LEAN_TIES    // balanced mix on a handful of priorities
    } t_lean;

    logic                 clk;
    logic                 rst_n            = 1'b0;
    logic                 in_valid         = 1'b0;
    logic                 in_stall;
    logic [ACT_W-1:0]     action           = ACT_PEEK;
    logic [PRIO_W-1:0]    new_priority     = '0;
    logic [JOB_W-1:0]     new_job_number   = '0;
    logic [PAGES_W-1:0]   new_pages        = '0;
    logic                 out_valid;
    logic                 out_stall        = 1'b0;
    logic [STAT_W-1:0]    status;
    logic                 top_valid;
    logic [PRIO_W-1:0]    top_priority;
    logic [JOB_W-1:0]     top_job_number;
    logic [PAGES_W-1:0]   top_pages;
    logic [CNT_OUT_W-1:0] item_count;

    int  fail_count;
    int  pending;
    int  beats_sent   = 0;
    int  idle_cycles  = 0;
    int  stall_left   = 0;
    bit  calm_tail    = 1'b0;
    bit  eager        = 1'b0;

    binary_max_heap_priority_queue #(
        .HEAP_DEPTH(HEAP_DEPTH)
    ) uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_action         (action),
        .i_new_priority   (new_priority),
        .i_new_job_number (new_job_number),
        .i_new_pages      (new_pages),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_status         (status),
        .o_top_valid      (top_valid),
        .o_top_priority   (top_priority),
        .o_top_job_number (top_job_number),
        .o_top_pages      (top_pages),
        .o_item_count     (item_count)
    );

    bmhpq_checker #(
        .HEAP_DEPTH(HEAP_DEPTH)
    ) chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_action         (action),
        .i_new_priority   (new_priority),
        .i_new_job_number (new_job_number),
        .i_new_pages      (new_pages),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_status         (status),
        .i_top_valid      (top_valid),
        .i_top_priority   (top_priority),
        .i_top_job_number (top_job_number),
        .i_top_pages      (top_pages),
        .i_item_count     (item_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Report-side stall: a random level held for a burst of random length, about 30% stalled.
    // The stall-free bursts give stretches of full throughput.
    always @(posedge clk) begin
        if (calm_tail) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left == 0) begin
            out_stall  <= ($urandom_range(0, 9) < 3);
            stall_left <= $urandom_range(1, 10);
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // Watchdog: any beat on either channel resets the count.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // One request beat. A random gap with valid low may come first; the payload then
    // holds until the beat is taken. Returns in the step of the accepting edge.
    task automatic send_beat(input logic [ACT_W-1:0]   act,
                             input logic [PRIO_W-1:0]  prio,
                             input logic [JOB_W-1:0]   job,
                             input logic [PAGES_W-1:0] pages);
        if (!calm_tail && !eager && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        new_priority   <= prio;
        new_job_number <= job;
        new_pages      <= pages;
        do @(posedge clk); while (in_stall);
        beats_sent++;
        if (beats_sent >= TOTAL_BEATS - CALM_BEATS) begin
            calm_tail <= 1'b1;
        end
    endtask

    task automatic send_random(input t_lean lean);
        int                roll;
        logic [ACT_W-1:0]  act;
        logic [PRIO_W-1:0] prio;
        roll = $urandom_range(0, 99);
        case (lean)
            LEAN_FILL:  act = (roll < 88) ? ACT_INSERT : ((roll < 95) ? ACT_REMOVE : ACT_PEEK);
            LEAN_DRAIN: act = (roll < 85) ? ACT_REMOVE : ((roll < 93) ? ACT_INSERT : ACT_PEEK);
            default:    act = (roll < 50) ? ACT_INSERT : ((roll < 85) ? ACT_REMOVE : ACT_PEEK);
        endcase
        if ($urandom_range(0, 39) == 0) begin
            act = ACT_SPARE;
        end
        // few distinct priorities make ties on the sift paths common
        if (lean == LEAN_TIES) begin
            prio = PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                : $urandom_range(252, 255));
        end else begin
            prio = PRIO_W'($urandom_range(0, 255));
        end
        send_beat(act, prio, JOB_W'($urandom_range(0, 65535)),
                  PAGES_W'($urandom_range(0, 65535)));
    endtask

    // Sender holds off until every report due has come back.
    task automatic hold_until_reported();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        t_lean lean;
        bit    paused_mid;
        paused_mid = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // empty heap: remove, peek and code three all flag empty
        send_beat(ACT_PEEK,   8'd0, 16'd0, 16'd0);
        send_beat(ACT_REMOVE, 8'd0, 16'd0, 16'd0);
        send_beat(ACT_SPARE,  8'd0, 16'd0, 16'd0);
        // field extremes; the 255 job climbs over the 0 one
        send_beat(ACT_INSERT, 8'd0,   16'h0000, 16'h0000);
        send_beat(ACT_INSERT, 8'd255, 16'hFFFF, 16'hFFFF);
        // equal priority never climbs past its parent
        send_beat(ACT_INSERT, 8'd255, 16'h0001, 16'h0002);
        send_beat(ACT_INSERT, 8'd128, 16'hAAAA, 16'h5555);
        send_beat(ACT_INSERT, 8'd128, 16'h5555, 16'hAAAA);
        send_beat(ACT_PEEK,   8'd7,   16'h1234, 16'h4321);
        send_beat(ACT_SPARE,  8'd7,   16'h1234, 16'h4321);
        repeat (6) send_beat(ACT_REMOVE, 8'd0, 16'd0, 16'd0);
        // equal children on the sift-down path: the left one must win
        send_beat(ACT_INSERT, 8'd9, 16'd1, 16'd10);
        send_beat(ACT_INSERT, 8'd7, 16'd2, 16'd20);
        send_beat(ACT_INSERT, 8'd7, 16'd3, 16'd30);
        send_beat(ACT_INSERT, 8'd1, 16'd4, 16'd40);
        send_beat(ACT_REMOVE, 8'd0, 16'd0, 16'd0);
        send_beat(ACT_REMOVE, 8'd0, 16'd0, 16'd0);
        hold_until_reported();

        // --- random part ---
        // first a straight fill past full, then a straight drain past empty
        repeat (HEAP_DEPTH + 8) begin
            send_beat(ACT_INSERT, PRIO_W'($urandom_range(0, 255)),
                      JOB_W'($urandom_range(0, 65535)),
                      PAGES_W'($urandom_range(0, 65535)));
        end
        repeat (HEAP_DEPTH + 6) send_beat(ACT_REMOVE, 8'd0, 16'd0, 16'd0);

        while (beats_sent < TOTAL_BEATS) begin
            lean  = t_lean'($urandom_range(0, 3));
            eager = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(30, 100)) begin
                if (beats_sent < TOTAL_BEATS) begin
                    send_random(lean);
                end
            end
            if (!paused_mid && beats_sent > TOTAL_BEATS / 2) begin
                hold_until_reported();
                paused_mid = 1'b1;
            end
        end

        // --- wind down ---
        hold_until_reported();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bmhpq_pkg.sv
rtl/bmhpq_ram.sv
rtl/binary_max_heap_priority_queue.sv
tb/bmhpq_checker.sv
tb/tb_binary_max_heap_priority_queue.sv
